FILE: rtl/core/ftr_pkg.sv
// Shared types, constants and helper functions for the frame to timecode resolver.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ftr_pkg;

	localparam int TIME_W   = 64;
	localparam int FRAME_W  = 48;
	localparam int DAY_W    = 25;   // nominal rate times seconds per day stays below 2**25
	localparam int NOM_W    = 8;
	localparam int SCNT_W   = 28;   // start timecode as a frame count
	localparam int CFG_IW   = 8;
	localparam int OUT_W    = 216;

	localparam logic [CFG_IW-1:0] REG_FPS        = 8'd0;
	localparam logic [CFG_IW-1:0] REG_REL_BASE   = 8'd1;
	localparam logic [CFG_IW-1:0] REG_FRAME_START = 8'd2;
	localparam logic [CFG_IW-1:0] REG_START_H    = 8'd3;
	localparam logic [CFG_IW-1:0] REG_START_M    = 8'd4;
	localparam logic [CFG_IW-1:0] REG_START_S    = 8'd5;
	localparam logic [CFG_IW-1:0] REG_START_F    = 8'd6;

	localparam logic [15:0] FPS_DEFAULT = 16'd6144;
	localparam logic [15:0] FPS_MIN     = 16'd256;
	localparam logic [15:0] FPS_MAX     = 16'd61440;
	localparam logic [8:0]  RATE_MAX    = 9'd240;
	localparam logic [7:0]  HOURS_MAX   = 8'd23;
	localparam logic [7:0]  MIN_SEC_MAX = 8'd59;
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

	localparam logic [FRAME_W-1:0] FRAME48_MAX = 48'h7FFF_FFFF_FFFF;

	// exact reciprocal multiplies: divide by 3600 for seconds below one day, by 60 below one hour
	localparam logic [22:0] DIV3600_MUL = 23'd4772186;
	localparam int          DIV3600_SH  = 34;
	localparam logic [12:0] DIV60_MUL   = 13'd4370;
	localparam int          DIV60_SH    = 18;

	typedef struct packed {
		logic [FRAME_W-1:0] eff;
		logic [TIME_W-1:0]  rel;
		logic [TIME_W-1:0]  fnum;
	} payload_t;

	typedef struct packed {
		logic [TIME_W-1:0] rel_base;
		logic [TIME_W-1:0] frame_start;
		logic              rate_ok;
		logic              start_ok;
		logic              fallback;
		logic [NOM_W-1:0]  nom;
		logic [DAY_W-1:0]  day;
		logic [SCNT_W-1:0] start_count;
	} cfg_t;

	typedef struct packed {
		logic [4:0] h;
		logic [5:0] m;
		logic [5:0] s;
		logic [7:0] f;
	} tc_t;

	// signed 64-bit add that clips at the signed limits
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] s;
		s = a + b;
		if ((a[TIME_W-1] == b[TIME_W-1]) && (s[TIME_W-1] != a[TIME_W-1])) begin
			s = a[TIME_W-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
		end
		return s;
	endfunction

	// one restoring remainder step against the day length
	function automatic logic [DAY_W-1:0] mod_step(input logic [DAY_W-1:0] r,
		input logic nbit, input logic [DAY_W-1:0] day);
		logic [DAY_W:0] t;
		t = {r, nbit};
		if (t >= {1'b0, day}) begin
			t = t - {1'b0, day};
		end
		return t[DAY_W-1:0];
	endfunction

endpackage

FILE: rtl/core/ftr_cfg.sv
// Configuration register file and values derived from it (nominal rate, day length,
// start frame count, validity flags). Depends on ftr_pkg.
module ftr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ftr_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [ftr_pkg::TIME_W-1:0]  cfg_data,
	output ftr_pkg::cfg_t               cfg
);

	logic [15:0]                 fps_q;
	logic [ftr_pkg::TIME_W-1:0]  rel_base_q;
	logic [ftr_pkg::TIME_W-1:0]  start_q;
	logic [7:0]                  sh_q, sm_q, ss_q, sf_q;
	logic                        rate_ok_q;
	logic [ftr_pkg::NOM_W-1:0]   nom_q;
	logic                        start_ok_q;
	logic [ftr_pkg::DAY_W-1:0]   day_q;
	logic [ftr_pkg::SCNT_W-1:0]  scnt_q;

	logic                        rate_ok_c;
	logic [15:0]                 fps_c;
	logic [16:0]                 fps_rnd;
	logic [8:0]                  nom9;
	logic [ftr_pkg::NOM_W-1:0]   nom_c;
	logic [19:0]                 secs_c;
	logic [ftr_pkg::SCNT_W-1:0]  scnt_c;
	logic [ftr_pkg::DAY_W-1:0]   day_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q      <= ftr_pkg::FPS_DEFAULT;
			rel_base_q <= '0;
			start_q    <= '0;
			sh_q       <= '0;
			sm_q       <= '0;
			ss_q       <= '0;
			sf_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ftr_pkg::REG_FPS:         fps_q      <= cfg_data[15:0];
				ftr_pkg::REG_REL_BASE:    rel_base_q <= cfg_data;
				ftr_pkg::REG_FRAME_START: start_q    <= cfg_data;
				ftr_pkg::REG_START_H:     sh_q       <= cfg_data[7:0];
				ftr_pkg::REG_START_M:     sm_q       <= cfg_data[7:0];
				ftr_pkg::REG_START_S:     ss_q       <= cfg_data[7:0];
				ftr_pkg::REG_START_F:     sf_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// first level: rate check and rounded nominal rate
	always_comb begin
		rate_ok_c = (fps_q >= ftr_pkg::FPS_MIN) && (fps_q <= ftr_pkg::FPS_MAX);
		fps_c     = rate_ok_c ? fps_q : ftr_pkg::FPS_DEFAULT;
		fps_rnd   = {1'b0, fps_c} + 17'd128;
		nom9      = fps_rnd[16:8];
		if (nom9 == 9'd0) begin
			nom_c = 8'd1;
		end else if (nom9 > ftr_pkg::RATE_MAX) begin
			nom_c = ftr_pkg::RATE_MAX[7:0];
		end else begin
			nom_c = nom9[7:0];
		end
	end

	// second level: everything that hangs off the nominal rate
	always_comb begin
		secs_c = ({12'd0, sh_q} * {8'd0, ftr_pkg::SECS_PER_HOUR})
			+ ({12'd0, sm_q} * {14'd0, ftr_pkg::SECS_PER_MIN}) + {12'd0, ss_q};
		scnt_c = ({8'd0, secs_c} * {20'd0, nom_q}) + {20'd0, sf_q};
		day_c  = {17'd0, nom_q} * {8'd0, ftr_pkg::SECS_PER_DAY};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_ok_q  <= 1'b1;
			nom_q      <= 8'd24;
			start_ok_q <= 1'b1;
			day_q      <= 25'd2073600;
			scnt_q     <= '0;
		end else begin
			rate_ok_q  <= rate_ok_c;
			nom_q      <= nom_c;
			start_ok_q <= (sh_q <= ftr_pkg::HOURS_MAX) && (sm_q <= ftr_pkg::MIN_SEC_MAX)
				&& (ss_q <= ftr_pkg::MIN_SEC_MAX) && (sf_q < nom_q);
			day_q      <= day_c;
			scnt_q     <= scnt_c;
		end
	end

	always_comb begin
		cfg.rel_base    = rel_base_q;
		cfg.frame_start = start_q;
		cfg.rate_ok     = rate_ok_q;
		cfg.start_ok    = start_ok_q;
		cfg.fallback    = !rate_ok_q || !start_ok_q;
		cfg.nom         = nom_q;
		cfg.day         = day_q;
		cfg.start_count = scnt_q;
	end

endmodule

FILE: rtl/core/ftr_front.sv
// Front stages: rounding of the Q47.16 time, saturating base adds, timecode source pick.
// Depends on ftr_pkg.
module ftr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ftr_pkg::TIME_W-1:0]  in_time,
	input  ftr_pkg::cfg_t               cfg,
	output logic                        out_valid,
	output logic [ftr_pkg::TIME_W-1:0]  out_tc,
	output ftr_pkg::payload_t           out_pay
);

	logic                         v_s1, v_s2;
	logic [ftr_pkg::FRAME_W-1:0]  eff_s1;
	ftr_pkg::payload_t            pay_s2;

	logic                         neg;
	logic [ftr_pkg::TIME_W-1:0]   mag, rsum;
	logic [ftr_pkg::FRAME_W-1:0]  r48, eff_c;
	logic [ftr_pkg::TIME_W-1:0]   eff64;

	always_comb begin
		neg   = in_time[63];
		mag   = neg ? (64'd0 - in_time) : in_time;
		rsum  = mag + 64'h8000;
		r48   = rsum[63:16];
		if (!neg) begin
			eff_c = r48[47] ? ftr_pkg::FRAME48_MAX : r48;
		end else begin
			eff_c = 48'd0 - r48;
		end
	end

	assign eff64 = {{16{eff_s1[47]}}, eff_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eff_s1      <= eff_c;
			pay_s2.eff  <= eff_s1;
			pay_s2.rel  <= ftr_pkg::sat_add(eff64, cfg.rel_base);
			pay_s2.fnum <= ftr_pkg::sat_add(eff64, cfg.frame_start);
			out_pay     <= pay_s2;
			out_tc      <= cfg.fallback ? pay_s2.rel :
				ftr_pkg::sat_add({36'd0, cfg.start_count}, {{16{pay_s2.eff[47]}}, pay_s2.eff});
		end
	end

endmodule

FILE: rtl/core/ftr_mod.sv
// Pipelined remainder of a signed 64-bit frame count by the day length, folded to 0..day-1.
// Four restoring steps per stage, sixteen stages. Depends on ftr_pkg.
module ftr_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ftr_pkg::TIME_W-1:0]  in_x,
	input  ftr_pkg::payload_t           in_pay,
	input  logic [ftr_pkg::DAY_W-1:0]   day,
	output logic                        out_valid,
	output logic [ftr_pkg::DAY_W-1:0]   out_wrapped,
	output ftr_pkg::payload_t           out_pay
);

	localparam int STAGES = 16;
	localparam int STEPS  = ftr_pkg::TIME_W / STAGES;

	logic                        v_s   [0:STAGES];
	logic                        neg_s [0:STAGES];
	logic [ftr_pkg::TIME_W-1:0]  mag_s [0:STAGES];
	logic [ftr_pkg::DAY_W-1:0]   rem_s [0:STAGES];
	ftr_pkg::payload_t           pay_s [0:STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= in_x[63];
			mag_s[0] <= in_x[63] ? (64'd0 - in_x) : in_x;
			rem_s[0] <= '0;
			pay_s[0] <= in_pay;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [ftr_pkg::DAY_W-1:0]  r_c;
		logic [ftr_pkg::TIME_W-1:0] m_c;

		always_comb begin
			r_c = rem_s[k];
			m_c = mag_s[k];
			for (int j = 0; j < STEPS; j++) begin
				r_c = ftr_pkg::mod_step(r_c, m_c[63], day);
				m_c = {m_c[62:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= r_c;
				mag_s[k+1] <= m_c;
				neg_s[k+1] <= neg_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	// fold a negative remainder up into the day
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_wrapped <= (neg_s[STAGES] && (rem_s[STAGES] != '0)) ?
				(day - rem_s[STAGES]) : rem_s[STAGES];
			out_pay     <= pay_s[STAGES];
		end
	end

endmodule

FILE: rtl/core/ftr_split.sv
// Split a frame count within one day into frames and hours, minutes, seconds.
// Pipelined division by the nominal rate, then reciprocal multiplies. Depends on ftr_pkg.
module ftr_split (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ftr_pkg::DAY_W-1:0]   in_wrapped,
	input  ftr_pkg::payload_t           in_pay,
	input  logic [ftr_pkg::NOM_W-1:0]   nom,
	output logic                        out_valid,
	output ftr_pkg::tc_t                out_tc,
	output ftr_pkg::payload_t           out_pay
);

	localparam int STAGES = 5;
	localparam int STEPS  = ftr_pkg::DAY_W / STAGES;

	logic                       v_s   [1:STAGES];
	logic [ftr_pkg::DAY_W-1:0]  n_s   [1:STAGES];
	logic [ftr_pkg::NOM_W-1:0]  r_s   [1:STAGES];
	ftr_pkg::payload_t          pay_s [1:STAGES];

	logic                       v_s6, v_s7, v_s8;
	logic [4:0]                 h_s6, h_s7, h_s8;
	logic [16:0]                tot_s6;
	logic [11:0]                soh_s7, soh_s8;
	logic [5:0]                 m_s8;
	logic [7:0]                 f_s6, f_s7, f_s8;
	ftr_pkg::payload_t          pay_s6, pay_s7, pay_s8;

	logic [39:0]                hprod;
	logic [16:0]                hsub;
	logic [24:0]                mprod;
	logic [11:0]                msub;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [ftr_pkg::DAY_W-1:0] n_in, n_c;
		logic [ftr_pkg::NOM_W-1:0] r_in, r_c;
		logic                      v_in;
		ftr_pkg::payload_t         p_in;
		logic [ftr_pkg::NOM_W:0]   t;

		if (k == 0) begin : g_first
			assign n_in = in_wrapped;
			assign r_in = '0;
			assign v_in = in_valid;
			assign p_in = in_pay;
		end else begin : g_next
			assign n_in = n_s[k];
			assign r_in = r_s[k];
			assign v_in = v_s[k];
			assign p_in = pay_s[k];
		end

		// restoring divide: quotient bits shift in where dividend bits leave
		always_comb begin
			n_c = n_in;
			r_c = r_in;
			t   = '0;
			for (int j = 0; j < STEPS; j++) begin
				t = {r_c, n_c[ftr_pkg::DAY_W-1]};
				if (t >= {1'b0, nom}) begin
					t   = t - {1'b0, nom};
					n_c = {n_c[ftr_pkg::DAY_W-2:0], 1'b1};
				end else begin
					n_c = {n_c[ftr_pkg::DAY_W-2:0], 1'b0};
				end
				r_c = t[ftr_pkg::NOM_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]   <= n_c;
				r_s[k+1]   <= r_c;
				pay_s[k+1] <= p_in;
			end
		end
	end

	always_comb begin
		hprod = n_s[STAGES][16:0] * ftr_pkg::DIV3600_MUL;
		hsub  = tot_s6 - ({12'd0, h_s6} * {5'd0, ftr_pkg::SECS_PER_HOUR});
		mprod = soh_s7 * ftr_pkg::DIV60_MUL;
		msub  = soh_s8 - ({6'd0, m_s8} * {6'd0, ftr_pkg::SECS_PER_MIN});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s6      <= v_s[STAGES];
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			out_valid <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s6     <= hprod[ftr_pkg::DIV3600_SH+4:ftr_pkg::DIV3600_SH];
			tot_s6   <= n_s[STAGES][16:0];
			f_s6     <= r_s[STAGES];
			pay_s6   <= pay_s[STAGES];
			h_s7     <= h_s6;
			soh_s7   <= hsub[11:0];
			f_s7     <= f_s6;
			pay_s7   <= pay_s6;
			h_s8     <= h_s7;
			soh_s8   <= soh_s7;
			m_s8     <= mprod[ftr_pkg::DIV60_SH+5:ftr_pkg::DIV60_SH];
			f_s8     <= f_s7;
			pay_s8   <= pay_s7;
			out_tc.h <= h_s8;
			out_tc.m <= m_s8;
			out_tc.s <= msub[5:0];
			out_tc.f <= f_s8;
			out_pay  <= pay_s8;
		end
	end

endmodule

FILE: rtl/core/frame_to_timecode_resolver_top.sv
// Throughput: one word per cycle; the whole pipeline advances when the output register
// is empty or being taken, so s_tready follows m_tready and a stall drops nothing.
// The 64-step day remainder (16 stages) and the 25-step rate divide set the depth.
// Reset (arst_n low, asynchronous) clears every valid bit and loads register defaults;
// written fields feed registered nominal rate, then the day length and start count.
// Depends on ftr_pkg, ftr_cfg, ftr_front, ftr_mod, ftr_split.
module frame_to_timecode_resolver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ftr_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [ftr_pkg::TIME_W-1:0]    cfg_data,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,  // [63:0] effect_time
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [47:0] effect_frame, [111:48] frame_relative, [175:112] frame_number,
	// [180:176] tc_hours, [186:181] tc_minutes, [192:187] tc_seconds,
	// [200:193] tc_frames, [201] rate_valid, [202] start_valid, [203] used_fallback,
	// [211:204] nominal_rate, [215:212] zero
	output logic [ftr_pkg::OUT_W-1:0]     m_tdata
);

	ftr_pkg::cfg_t      cfg;
	logic               adv;

	logic               fr_valid;
	logic [63:0]        fr_tc;
	ftr_pkg::payload_t  fr_pay;

	logic               md_valid;
	logic [ftr_pkg::DAY_W-1:0] md_wrapped;
	ftr_pkg::payload_t  md_pay;

	ftr_pkg::tc_t       sp_tc;
	ftr_pkg::payload_t  sp_pay;

	// advance every stage together; hold all of them while a result waits
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	ftr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// round, add the bases, pick start timecode or relative frame
	ftr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.in_time   (s_tdata),
		.cfg       (cfg),
		.out_valid (fr_valid),
		.out_tc    (fr_tc),
		.out_pay   (fr_pay)
	);

	// wrap into one day of frames
	ftr_mod u_mod (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (fr_valid),
		.in_x        (fr_tc),
		.in_pay      (fr_pay),
		.day         (cfg.day),
		.out_valid   (md_valid),
		.out_wrapped (md_wrapped),
		.out_pay     (md_pay)
	);

	// break into frames, seconds, minutes, hours; the last stage is the output register
	ftr_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (md_valid),
		.in_wrapped (md_wrapped),
		.in_pay     (md_pay),
		.nom        (cfg.nom),
		.out_valid  (m_tvalid),
		.out_tc     (sp_tc),
		.out_pay    (sp_pay)
	);

	// user keeps flags and rate static while words are in flight (unchecked); taken live
	assign m_tdata = {4'd0, cfg.nom, cfg.fallback, cfg.start_ok, cfg.rate_ok,
		sp_tc.f, sp_tc.s, sp_tc.m, sp_tc.h, sp_pay.fnum, sp_pay.rel, sp_pay.eff};

endmodule

FILE: rtl/core/ftr_checker.sv
// Port-level checks of the result stream and a bind onto the top level.
// Depends on ftr_pkg and frame_to_timecode_resolver_top.
module ftr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [ftr_pkg::OUT_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hours: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[180:176] <= 5'd23)
		else $error("hours out of range");

	a_min_sec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[186:181] <= 6'd59) && (m_tdata[192:187] <= 6'd59))
		else $error("minutes or seconds out of range");

	a_frames: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[211:204] != 8'd0) && (m_tdata[200:193] < m_tdata[211:204]))
		else $error("frame field not below nominal rate");

	a_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[203] == !(m_tdata[201] && m_tdata[202]))
		else $error("fallback flag disagrees with validity flags");

endmodule

bind frame_to_timecode_resolver_top ftr_checker u_ftr_checker (.*);
